/* rtl/core/mrht_pkg.sv */
// mrht_pkg: shared widths and constants for the meeting-room heap tracker
// no dependencies; imported by mrht_ram, min_rooms_heap_tracker and the testbench
package mrht_pkg;

  localparam int TIME_W          = 32;
  localparam int OUT_W           = 11;
  localparam int DEF_HEAP_DEPTH  = 1024;
  localparam int S_TDATA_W       = 64;
  localparam int M_TDATA_W       = 24;

  localparam logic [OUT_W-1:0] OUT_MAX = 11'h7ff;

endpackage

/* rtl/core/min_rooms_heap_tracker.sv */
// min_rooms_heap_tracker: meeting-room counter built on a min-heap of end times
// depends on mrht_pkg and mrht_ram
//
// Usage:
//   Input stream s_*: s_tdata = {end_time, start_time}, s_tuser = new_set.
//   Intervals must arrive ordered by start time, then end time.
//   Output stream m_*: one transaction per input transaction carrying
//   rooms_in_use, peak_rooms and the sticky overflowed flag.
//   Per interval the sequencer accepts it, then for every freed room reads
//   the last entry and walks it down the heap, reading the left and right
//   children and comparing, until it stops at a leaf or on a compare; a
//   last top check ends the pops, then the insert walks the new end time
//   up the heap (a direct write into an empty heap, no write into a full
//   one), and then the output register is loaded. The cost grows with the
//   number of freed rooms and with log2 of the heap depth; all heap reads
//   share the single memory read port.
//   s_tready is high only while the sequencer waits for a new interval.
//   A stalled receiver only holds the sequencer when the next result is
//   ready and the output register is still full.
//   Reset empties the heap and clears the peak and overflow flag; the heap
//   memory is not cleared, only entries below the count are ever read.
module min_rooms_heap_tracker import mrht_pkg::*; #(
  parameter int HEAP_DEPTH = DEF_HEAP_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // start_time[31:0], end_time[63:32]
  input  logic                 s_tuser,   // new_set
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // rooms_in_use[10:0], peak_rooms[21:11],
                                          // overflowed[22], zero[23]
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = AW + 2;
  localparam int SW = (CW > OUT_W) ? CW : OUT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_POP_CHK  = 4'd1;
  localparam logic [3:0] ST_POP_LAST = 4'd2;
  localparam logic [3:0] ST_SD_RDL   = 4'd3;
  localparam logic [3:0] ST_SD_RDR   = 4'd4;
  localparam logic [3:0] ST_SD_CMP   = 4'd5;
  localparam logic [3:0] ST_PUSH     = 4'd6;
  localparam logic [3:0] ST_PU_CMP   = 4'd7;
  localparam logic [3:0] ST_PU_TOP   = 4'd8;
  localparam logic [3:0] ST_DONE     = 4'd9;

  logic [3:0]               state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            peak, peak_next;
  logic                     ovf, ovf_next;
  logic signed [TIME_W-1:0] start_t, start_t_next;
  logic signed [TIME_W-1:0] end_t, end_t_next;
  logic signed [TIME_W-1:0] cur, cur_next;
  logic signed [TIME_W-1:0] top_val, top_val_next;
  logic signed [TIME_W-1:0] lval, lval_next;
  logic [AW-1:0]            pos, pos_next;
  logic                     out_load;
  logic [M_TDATA_W-1:0]     out_word;

  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic signed [TIME_W-1:0] wdata;
  logic [TIME_W-1:0]        rdata_u;
  logic signed [TIME_W-1:0] rdata;

  logic [IW-1:0]            l_idx, r_idx, cnt_ext;
  logic                     l_ok, r_ok, take_r;
  logic [AW-1:0]            pos_m1, up, up_m1, up_up;
  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            min_idx;
  logic signed [TIME_W-1:0] min_val;
  logic [SW-1:0]            cnt_w, peak_w;
  logic [OUT_W-1:0]         cnt_sat, peak_sat;

  mrht_ram #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (TIME_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_u)
  );

  assign rdata   = $signed(rdata_u);
  assign l_idx   = {1'b0, pos, 1'b1};
  assign r_idx   = l_idx + IW'(1);
  assign cnt_ext = IW'(count);
  assign l_ok    = l_idx < cnt_ext;
  assign r_ok    = r_idx < cnt_ext;
  assign pos_m1  = pos - AW'(1);
  assign up      = pos_m1 >> 1;
  assign up_m1   = up - AW'(1);
  assign up_up   = up_m1 >> 1;
  assign cnt_m1  = count - CW'(1);
  assign take_r  = r_ok && (rdata < lval);
  assign min_idx = take_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
  assign min_val = take_r ? rdata : lval;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    count_next   = count;
    peak_next    = peak;
    ovf_next     = ovf;
    start_t_next = start_t;
    end_t_next   = end_t;
    cur_next     = cur;
    top_val_next = top_val;
    lval_next    = lval;
    pos_next     = pos;
    out_load     = 1'b0;
    we           = 1'b0;
    waddr        = pos;
    wdata        = cur;
    raddr        = pos;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          start_t_next = $signed(s_tdata[TIME_W-1:0]);
          end_t_next   = $signed(s_tdata[2*TIME_W-1:TIME_W]);
          if (s_tuser) begin
            count_next = '0;
            peak_next  = '0;
            ovf_next   = 1'b0;
          end
          state_next = ST_POP_CHK;
        end
      end
      ST_POP_CHK: begin
        if ((count != '0) && (top_val <= start_t)) begin
          raddr      = cnt_m1[AW-1:0];
          count_next = cnt_m1;
          state_next = ST_POP_LAST;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_POP_LAST: begin
        cur_next = rdata;
        pos_next = '0;
        if (count == '0) begin
          state_next = ST_POP_CHK;
        end else begin
          state_next = ST_SD_RDL;
        end
      end
      ST_SD_RDL: begin
        if (l_ok) begin
          raddr      = l_idx[AW-1:0];
          state_next = ST_SD_RDR;
        end else begin
          we         = 1'b1;
          wdata      = cur;
          if (pos == '0) begin
            top_val_next = cur;
          end
          state_next = ST_POP_CHK;
        end
      end
      ST_SD_RDR: begin
        lval_next  = rdata;
        raddr      = r_idx[AW-1:0];
        state_next = ST_SD_CMP;
      end
      ST_SD_CMP: begin
        we = 1'b1;
        if (min_val < cur) begin
          wdata = min_val;
          if (pos == '0) begin
            top_val_next = min_val;
          end
          pos_next   = min_idx;
          state_next = ST_SD_RDL;
        end else begin
          wdata = cur;
          if (pos == '0) begin
            top_val_next = cur;
          end
          state_next = ST_POP_CHK;
        end
      end
      ST_PUSH: begin
        if (count < DEPTH_C) begin
          cur_next   = end_t;
          pos_next   = count[AW-1:0];
          count_next = count + CW'(1);
          if (count == '0) begin
            we           = 1'b1;
            waddr        = '0;
            wdata        = end_t;
            top_val_next = end_t;
            state_next   = ST_DONE;
          end else begin
            raddr      = cnt_m1[AW-1:0] >> 1;
            state_next = ST_PU_CMP;
          end
        end else begin
          ovf_next   = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_PU_CMP: begin
        we = 1'b1;
        if (rdata <= cur) begin
          wdata      = cur;
          state_next = ST_DONE;
        end else begin
          wdata    = rdata;
          pos_next = up;
          raddr    = up_up;
          if (up == '0) begin
            state_next = ST_PU_TOP;
          end else begin
            state_next = ST_PU_CMP;
          end
        end
      end
      ST_PU_TOP: begin
        we           = 1'b1;
        waddr        = '0;
        wdata        = cur;
        top_val_next = cur;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          if (count > peak) begin
            peak_next = count;
          end
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // saturate counts into the result fields
  assign cnt_w    = SW'(count);
  assign peak_w   = SW'(peak_next);
  assign cnt_sat  = (cnt_w > SW'(OUT_MAX)) ? OUT_MAX : cnt_w[OUT_W-1:0];
  assign peak_sat = (peak_w > SW'(OUT_MAX)) ? OUT_MAX : peak_w[OUT_W-1:0];
  assign out_word = {1'b0, ovf, peak_sat, cnt_sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      peak     <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      peak  <= peak_next;
      ovf   <= ovf_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_t <= start_t_next;
    end_t   <= end_t_next;
    cur     <= cur_next;
    top_val <= top_val_next;
    lval    <= lval_next;
    pos     <= pos_next;
    if (out_load) begin
      m_tdata <= out_word;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("heap count above depth");

  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    we |-> (CW'(waddr) < count_next))
    else $error("heap write outside occupied range");

  a_peak_cover: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (peak >= count))
    else $error("peak below room count");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> (count == DEPTH_C))
    else $error("overflow raised with room left in heap");

endmodule

/* rtl/core/mrht_ram.sv */
// mrht_ram: single-port-write, single-port-read memory with registered read data
// depends on mrht_pkg for the default depth and data width
module mrht_ram import mrht_pkg::*; #(
  parameter int DEPTH = DEF_HEAP_DEPTH,
  parameter int WIDTH = TIME_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking stream test of min_rooms_heap_tracker with its own heap predictor
// depends on mrht_pkg and the min_rooms_heap_tracker rtl; reads no files, needs no arguments
// directed corner intervals, a heap-fill overflow run and random interval sets under stalls
module testbench;
  import mrht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH        = DEF_HEAP_DEPTH;
  localparam int          T_MAX        = 32'sh7fff_ffff;
  localparam int          T_MIN        = int'(32'h8000_0000);
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam longint      LIMIT_CYCLES = 1_000_000;
  localparam int unsigned PRINT_CAP    = 40;

  typedef struct {
    int start_t;
    int end_t;
    bit new_set;
  } meeting_t;

  typedef struct {
    logic [OUT_W-1:0] rooms;
    logic [OUT_W-1:0] peak;
    logic             ovf;
  } room_report_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  meeting_t     meetings_to_send[$];
  room_report_t room_counts_due[$];
  meeting_t     meeting_on_bus;

  int          end_heap_m[DEPTH];
  int unsigned heap_cnt  = 0;
  int unsigned peak_cnt  = 0;
  bit          ovf_flag  = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;

  int unsigned errors        = 0;
  int unsigned sent          = 0;
  int unsigned received      = 0;
  int unsigned input_stalls  = 0;
  int unsigned max_rooms     = 0;
  int unsigned ovf_results   = 0;
  longint      cycles        = 0;

  min_rooms_heap_tracker #(.HEAP_DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    errors++;
    if (errors <= PRINT_CAP)
      $display("[%0t] mismatch on result %0d: %s expected %0d got %0d",
               $time, received, what, exp_v, got_v);
  endtask

  function automatic logic [OUT_W-1:0] sat_count(int unsigned v);
    return (v > OUT_MAX) ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  function automatic void push_end_time(int v);
    int unsigned pos;
    int unsigned up;
    int          t;
    pos = heap_cnt;
    end_heap_m[pos] = v;
    heap_cnt = pos + 1;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (end_heap_m[up] <= end_heap_m[pos]) break;
      t = end_heap_m[up];
      end_heap_m[up] = end_heap_m[pos];
      end_heap_m[pos] = t;
      pos = up;
    end
  endfunction

  function automatic void pop_earliest();
    int unsigned pos;
    int unsigned l;
    int unsigned r;
    int unsigned best;
    int          t;
    pos = 0;
    heap_cnt = heap_cnt - 1;
    end_heap_m[0] = end_heap_m[heap_cnt];
    forever begin
      l = 2 * pos + 1;
      r = l + 1;
      best = pos;
      if (l < heap_cnt && end_heap_m[l] < end_heap_m[best]) best = l;
      if (r < heap_cnt && end_heap_m[r] < end_heap_m[best]) best = r;
      if (best == pos) break;
      t = end_heap_m[pos];
      end_heap_m[pos] = end_heap_m[best];
      end_heap_m[best] = t;
      pos = best;
    end
  endfunction

  function automatic void book_room(meeting_t m);
    room_report_t r;
    if (m.new_set) begin
      heap_cnt = 0;
      peak_cnt = 0;
      ovf_flag = 1'b0;
    end
    while (heap_cnt > 0 && end_heap_m[0] <= m.start_t) pop_earliest();
    if (heap_cnt < DEPTH) push_end_time(m.end_t);
    else ovf_flag = 1'b1;
    if (heap_cnt > peak_cnt) peak_cnt = heap_cnt;
    r.rooms = sat_count(heap_cnt);
    r.peak  = sat_count(peak_cnt);
    r.ovf   = ovf_flag;
    room_counts_due.push_back(r);
  endfunction

  function automatic int clamp_time(longint v);
    if (v > longint'(T_MAX)) return T_MAX;
    if (v < longint'(T_MIN)) return T_MIN;
    return int'(v);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        book_room(meeting_on_bus);
        sent++;
      end
      if (s_tvalid && !s_tready) input_stalls++;
      if (!s_tvalid || s_tready) begin
        if (meetings_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          meeting_on_bus = meetings_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {meeting_on_bus.end_t, meeting_on_bus.start_t};
          s_tuser  <= meeting_on_bus.new_set;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req) hold_cnt <= hold_cnt + 1;
    else hold_cnt <= 0;
  end

  // monitor
  always @(posedge clk) begin
    room_report_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        received++;
        if (m_tdata[OUT_W-1:0] > max_rooms) max_rooms = m_tdata[OUT_W-1:0];
        if (m_tdata[2*OUT_W]) ovf_results++;
        if (room_counts_due.size() == 0) begin
          report_mismatch("unexpected transaction, pending results", 0, 1);
        end else begin
          exp_r = room_counts_due.pop_front();
          if (m_tdata[OUT_W-1:0] !== exp_r.rooms)
            report_mismatch("rooms_in_use", exp_r.rooms, m_tdata[OUT_W-1:0]);
          if (m_tdata[2*OUT_W-1:OUT_W] !== exp_r.peak)
            report_mismatch("peak_rooms", exp_r.peak, m_tdata[2*OUT_W-1:OUT_W]);
          if (m_tdata[2*OUT_W] !== exp_r.ovf)
            report_mismatch("overflowed", exp_r.ovf, m_tdata[2*OUT_W]);
          if (m_tdata[M_TDATA_W-1] !== 1'b0)
            report_mismatch("pad bit", 0, m_tdata[M_TDATA_W-1]);
        end
      end
      if (hold_req && hold_cnt < HOLD_LEN) m_tready <= 1'b0;
      else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d sent, %0d received", cycles, sent, received);
      $display("** min_rooms_heap_tracker: FAILED **");
      $finish;
    end
  end

  task automatic add_meeting(int s, int e, bit ns);
    meeting_t m;
    m.start_t = s;
    m.end_t   = e;
    m.new_set = ns;
    meetings_to_send.push_back(m);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (meetings_to_send.size() > 0 || s_tvalid || room_counts_due.size() > 0)
      @(negedge clk);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic add_directed();
    add_meeting(T_MIN, T_MIN, 1'b1);
    add_meeting(T_MIN, T_MAX, 1'b0);
    add_meeting(0, 10, 1'b0);
    add_meeting(10, 20, 1'b0);
    add_meeting(10, 5, 1'b0);
    // start going backwards
    add_meeting(5, 7, 1'b0);
    add_meeting(-1, -1, 1'b0);
    add_meeting(-1, 0, 1'b0);
    add_meeting(T_MAX, T_MAX, 1'b0);
    // clear while rooms are still held
    add_meeting(0, 32'sh7fff_0000, 1'b1);
    add_meeting(-5, -10, 1'b1);
    add_meeting(-5, -10, 1'b0);
    add_meeting(-5, -10, 1'b0);
    add_meeting(-10, -10, 1'b0);
    add_meeting(int'(32'haaaa_aaaa), int'(32'h5555_5555), 1'b1);
    add_meeting(int'(32'h5555_5555), int'(32'haaaa_aaaa), 1'b0);
    add_meeting(int'(32'h5555_5555), int'(32'h5555_5555), 1'b0);
    add_meeting(100, 200, 1'b1);
    add_meeting(100, 200, 1'b0);
    add_meeting(150, 300, 1'b0);
    add_meeting(200, 250, 1'b0);
    add_meeting(300, 300, 1'b0);
    add_meeting(T_MAX, T_MIN, 1'b0);
    add_meeting(T_MIN, T_MIN, 1'b0);
  endtask

  task automatic add_random_sets(int unsigned total);
    int unsigned added;
    int unsigned n;
    int unsigned i;
    int unsigned step_max;
    int unsigned dur_max;
    longint      t;
    longint      e;
    meeting_t    m;
    added = 0;
    while (added < total) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      case ($urandom_range(0, 3))
        0: begin
          step_max = 4;
          dur_max  = 40;
        end
        1: begin
          step_max = 100;
          dur_max  = 2000;
        end
        2: begin
          step_max = 1000;
          dur_max  = 1000;
        end
        default: begin
          step_max = 1 << 20;
          dur_max  = 1 << 24;
        end
      endcase
      t = longint'($signed($urandom));
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          m.start_t = $urandom;
          m.end_t   = $urandom;
          m.new_set = ($urandom_range(0, 7) == 0);
        end else begin
          if ($urandom_range(0, 24) == 0) t -= $urandom_range(0, step_max * 4);
          else t += $urandom_range(0, step_max);
          e = t + $urandom_range(0, dur_max);
          if ($urandom_range(0, 19) == 0) e = t - $urandom_range(1, dur_max);
          m.start_t = clamp_time(t);
          m.end_t   = clamp_time(e);
          m.new_set = (i == 0) && ($urandom_range(0, 5) != 0);
        end
        meetings_to_send.push_back(m);
      end
      added += n;
    end
  endtask

  task automatic add_heap_fill();
    int unsigned i;
    for (i = 0; i < DEPTH + 6; i++)
      add_meeting(-1000000 + int'(i), int'($urandom & 32'h7fff_ffff), i == 0);
    // full heap: no pop, a few pops, then free everything
    add_meeting(-1, 5, 1'b0);
    add_meeting(0, 1, 1'b0);
    add_meeting(1 << 24, T_MAX, 1'b0);
    add_meeting(T_MAX, 0, 1'b0);
    add_meeting(0, 0, 1'b0);
    add_meeting(1, 2, 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    add_directed();
    wait_drained();

    set_idling(0, 0);
    add_random_sets(100);
    wait_drained();
    set_idling(54, 0);
    add_random_sets(100);
    wait_drained();
    set_idling(0, 54);
    add_random_sets(100);
    wait_drained();
    set_idling(11, 11);
    add_random_sets(100);
    add_heap_fill();
    wait_drained();

    // receiver holds off while the sender keeps offering
    set_idling(0, 0);
    add_random_sets(40);
    @(negedge clk);
    hold_req = 1'b1;
    while (hold_cnt < HOLD_LEN) @(negedge clk);
    hold_req = 1'b0;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (room_counts_due.size() != 0)
      report_mismatch("results never delivered", 0, room_counts_due.size());

    $display("%0d intervals sent, %0d results checked, peak rooms seen %0d, overflowed in %0d",
             sent, received, max_rooms, ovf_results);
    $display("input stalled for %0d cycles; %0d mismatches", input_stalls, errors);
    if (errors == 0) begin
      $display("** min_rooms_heap_tracker: PASSED **");
    end else begin
      $display("** min_rooms_heap_tracker: FAILED **");
    end
    $finish;
  end

endmodule
